[src/sxwh_pkg.sv]
// ----------------------------------------------------------------------------
// sxwh_pkg
// Shared types and constants for the shift-add-xor word hash block.
// ----------------------------------------------------------------------------
package sxwh_pkg;

    localparam int HASH_W    = 32;
    localparam int SLOT_W    = 31;
    localparam int BYTE_W    = 8;
    localparam int HASH_SHL  = 5;
    localparam int HASH_SHR  = 2;
    localparam logic [HASH_W-1:0] HASH_LOW_MASK = 32'h7fff_ffff;

    // One restoring-division step per quotient bit.
    localparam int DIV_STEPS = SLOT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // APB register map (byte address = 4 * index)
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam logic REG_HASH_SEED  = 1'b0;
    localparam logic REG_TABLE_SIZE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_LO,
        ST_ADD_HI,
        ST_DIV,
        ST_OUT
    } sxwh_state_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash_seed;
        logic [SLOT_W-1:0] table_size;
    } sxwh_cfg_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot_index;
    } sxwh_res_t;

endpackage

[src/sxwh_if.sv]
// ----------------------------------------------------------------------------
// sxwh_if
// Valid/ready channels for the byte stream and the slot results.
// ----------------------------------------------------------------------------
interface sxwh_byte_if import sxwh_pkg::*; (input logic clk);
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface sxwh_slot_if import sxwh_pkg::*; (input logic clk);
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot_index;

    modport source (output valid, output slot_index, input ready);
    modport sink   (input valid, input slot_index, output ready);
endinterface

[src/sxwh_core.sv]
// ----------------------------------------------------------------------------
// sxwh_core
// Sequencer around one shared 33-bit adder: two hash passes per byte,
// then a bit-serial restoring modulo on the final byte (skipped when table_size is zero).
// ----------------------------------------------------------------------------
module sxwh_core
    import sxwh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  sxwh_cfg_t         cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    output sxwh_res_t         res,
    input  logic              res_ready
);

    sxwh_state_t       state_reg, state_next;
    logic [HASH_W-1:0] running_hash_reg, running_hash_next;
    logic [HASH_W-1:0] partial_reg, partial_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              in_word_reg, in_word_next;
    logic [SLOT_W-1:0] rem_reg, rem_next;
    logic [SLOT_W-1:0] dvd_reg, dvd_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] result_reg, result_next;

    logic [HASH_W:0]   add_a, add_b, add_sum;
    logic              add_cin;
    logic [HASH_W-1:0] hash_new;
    logic [HASH_W-1:0] rem_shift;

    // Shared adder
    assign add_sum   = add_a + add_b + {{HASH_W{1'b0}}, add_cin};
    assign hash_new  = running_hash_reg ^ add_sum[HASH_W-1:0];
    assign rem_shift = {rem_reg, dvd_reg[SLOT_W-1]};

    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            ST_ADD_LO:
            begin
                add_a = {1'b0, running_hash_reg << HASH_SHL};
                add_b = {1'b0, {(HASH_W-BYTE_W){byte_reg[BYTE_W-1]}}, byte_reg};
            end
            ST_ADD_HI:
            begin
                add_a = {1'b0, partial_reg};
                add_b = {1'b0, running_hash_reg >> HASH_SHR};
            end
            ST_DIV:
            begin
                add_a   = {1'b0, rem_shift};
                add_b   = ~{2'b00, cfg.table_size};
                add_cin = 1'b1;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        running_hash_next = running_hash_reg;
        partial_next      = partial_reg;
        byte_next         = byte_reg;
        last_next         = last_reg;
        in_word_next      = in_word_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        count_next        = count_reg;
        result_next       = result_reg;
        in_ready          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    running_hash_next = in_word_reg ? running_hash_reg : cfg.hash_seed;
                    byte_next         = in_byte;
                    last_next         = in_last;
                    state_next        = ST_ADD_LO;
                end
            end
            ST_ADD_LO:
            begin
                partial_next = add_sum[HASH_W-1:0];
                state_next   = ST_ADD_HI;
            end
            ST_ADD_HI:
            begin
                running_hash_next = hash_new;
                if (!last_reg)
                begin
                    in_word_next = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    in_word_next = 1'b0;
                    dvd_next     = hash_new[SLOT_W-1:0];
                    rem_next     = '0;
                    count_next   = CNT_W'(DIV_STEPS - 1);
                    result_next  = hash_new[SLOT_W-1:0];
                    // Zero table size bypasses the modulo.
                    state_next   = (cfg.table_size == '0) ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = add_sum[HASH_W] ? rem_shift[SLOT_W-1:0] : add_sum[SLOT_W-1:0];
                dvd_next = dvd_reg << 1;
                if (count_reg == '0)
                begin
                    result_next = rem_next;
                    state_next  = ST_OUT;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            ST_OUT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res.valid      = (state_reg == ST_OUT);
    assign res.slot_index = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            in_word_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_word_reg <= in_word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        running_hash_reg <= running_hash_next;
        partial_reg      <= partial_next;
        byte_reg         <= byte_next;
        last_reg         <= last_next;
        rem_reg          <= rem_next;
        dvd_reg          <= dvd_next;
        count_reg        <= count_next;
        result_reg       <= result_next;
    end

endmodule

[src/shift_add_xor_word_hash.sv]
// ----------------------------------------------------------------------------
// shift_add_xor_word_hash
// Byte-serial shift-add-xor word hash with a run-time table-size modulo.
// ----------------------------------------------------------------------------
// Words arrive one byte per transfer on byte_in, with last_byte set on the
// final byte. The running hash starts at hash_seed and takes, per byte,
// h ^= (h << 5) + signed byte + (h >> 2). After the final byte the block
// returns (h & 0x7fffffff) mod table_size on slot_out (table_size of zero
// skips the modulo). All arithmetic goes through one shared 33-bit adder
// under a small sequencer: a non-final byte occupies the block for its
// transfer plus two adder passes; a final byte for its transfer, two hash
// passes, 31 restoring-division steps of one quotient bit each and the
// hand-off, with no division steps when table_size is zero. An output
// register holds the slot until it is taken, so the next word's bytes are
// accepted meanwhile. There is no clearing pass after reset. Write the
// registers over APB only while no word is in flight; hash_seed sits at
// byte address 0 and table_size at 4.
// ----------------------------------------------------------------------------
module shift_add_xor_word_hash
    import sxwh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    sxwh_byte_if.sink          byte_in,
    sxwh_slot_if.source        slot_out
);

    sxwh_cfg_t         cfg_reg;
    sxwh_res_t         res;
    logic              res_ready;
    logic              cfg_write;
    logic              out_valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              out_load;

    // ---- configuration registers ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hash_seed  <= '0;
            cfg_reg.table_size <= SLOT_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_HASH_SEED:  cfg_reg.hash_seed  <= pwdata;
                REG_TABLE_SIZE: cfg_reg.table_size <= pwdata[SLOT_W-1:0];
                default:        cfg_reg.hash_seed  <= cfg_reg.hash_seed;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_HASH_SEED:  prdata = cfg_reg.hash_seed;
            REG_TABLE_SIZE: prdata = {{(PDATA_W-SLOT_W){1'b0}}, cfg_reg.table_size};
            default:        prdata = '0;
        endcase
    end

    // ---- hash and modulo sequencer ----
    sxwh_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (byte_in.valid),
        .in_ready  (byte_in.ready),
        .in_byte   (byte_in.byte_value),
        .in_last   (byte_in.last_byte),
        .res       (res),
        .res_ready (res_ready)
    );

    // ---- output register ----
    // Load a new slot when the register is empty or drains this cycle.
    assign out_load  = res.valid && (!out_valid_reg || slot_out.ready);
    assign res_ready = out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (slot_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            slot_reg <= res.slot_index;
        end
    end

    assign slot_out.valid      = out_valid_reg;
    assign slot_out.slot_index = slot_reg;

`ifndef SYNTHESIS
    // The sequencer never takes a byte while a finished slot waits for hand-off.
    a_no_accept_while_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        res.valid |-> !byte_in.ready)
        else $error("byte accepted while a result is pending");

    // A pending result stays put until the output register takes it.
    a_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (res.valid && !res_ready) |=> (res.valid && $stable(res.slot_index)))
        else $error("pending result dropped or changed");

    // A loaded slot is presented on the next cycle.
    a_load_shows: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_load |=> (slot_out.valid && slot_out.slot_index == $past(res.slot_index)))
        else $error("loaded slot not presented");
`endif

endmodule
